@@ hw/rtl/cfhd_pkg.sv @@
package cfhd_pkg;

  localparam int unsigned CountW = 4;
  localparam int unsigned AccW   = 17;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_RANGE = 2'd1,
    ERR_LONG  = 2'd2
  } err_t;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       struct_start;
  } in_t;

  typedef struct packed {
    logic signed [15:0] header_id;
    logic [3:0]         header_type;
    logic               is_stop;
    err_t               error_code;
  } out_t;

  // The accumulator keeps the low 17 payload bits, of which only the low 16 can
  // form a legal id; anything higher is folded into a sticky overflow flag.
  typedef struct packed {
    logic [15:0]       prev_id;
    logic              in_varint;
    logic [3:0]        pending_type;
    logic [AccW-1:0]   acc;
    logic              ovf;
    logic [CountW-1:0] count;
  } state_t;

endpackage

@@ hw/rtl/compact_field_header_decoder.sv @@
// Field header decoder for the compact struct encoding. Takes one stream
// byte per cycle while the result side keeps up. An input register and a
// result register sit either side of the decode logic; a header result is
// held in the result register until accepted. A result held by a stalled
// receiver also holds the input register, so the input stalls once both
// registers are full. Bytes that only open or continue a varint id give no
// result, but an over-long varint gives ERR_LONG. Assert struct_start on
// the first byte of a struct to restart delta ids from zero.
module compact_field_header_decoder #(
  parameter int unsigned MAX_VARINT_BYTES = 10
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  cfhd_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output cfhd_pkg::out_t out_data
);

  logic             s1_valid_r;
  cfhd_pkg::in_t    s1_data_r;
  cfhd_pkg::state_t st_r;
  cfhd_pkg::state_t st_nxt;
  logic             res_valid;
  cfhd_pkg::out_t   res;
  logic             out_valid_r;
  cfhd_pkg::out_t   out_data_r;
  logic             s1_adv;

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  cfhd_core #(
    .MAX_VARINT_BYTES(MAX_VARINT_BYTES)
  ) u_core (
    .st       (st_r),
    .din      (s1_data_r),
    .st_nxt   (st_nxt),
    .res_valid(res_valid),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= '0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s1_adv) begin
        st_r        <= st_nxt;
        out_valid_r <= res_valid;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_data;
    end
    if (s1_adv && res_valid) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ hw/rtl/cfhd_core.sv @@
module cfhd_core #(
  parameter int unsigned MAX_VARINT_BYTES = 10
) (
  input  cfhd_pkg::state_t st,
  input  cfhd_pkg::in_t    din,
  output cfhd_pkg::state_t st_nxt,
  output logic             res_valid,
  output cfhd_pkg::out_t   res
);

  localparam logic [cfhd_pkg::CountW-1:0] MaxBytes = cfhd_pkg::CountW'(MAX_VARINT_BYTES);

  logic [15:0]                 prev;
  logic [3:0]                  delta;
  logic [6:0]                  pay;
  logic [cfhd_pkg::AccW-1:0]   acc_new;
  logic                        ovf_new;
  logic [cfhd_pkg::CountW-1:0] cnt_inc;
  logic [15:0]                 mag;

  always_comb begin
    prev    = din.struct_start ? 16'd0 : st.prev_id;
    delta   = din.byte_value[7:4];
    pay     = din.byte_value[6:0];
    acc_new = st.acc;
    ovf_new = st.ovf;
    cnt_inc = st.count + 1'b1;

    // place this byte's seven payload bits at 7 * count; bits past 16 go to the overflow flag
    case (st.count)
      4'd0: acc_new[6:0]   = pay;
      4'd1: acc_new[13:7]  = pay;
      4'd2: begin
        acc_new[16:14] = pay[2:0];
        ovf_new        = st.ovf | (pay[6:3] != 4'd0);
      end
      4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8: ovf_new = st.ovf | (pay != 7'd0);
      4'd9: ovf_new = st.ovf | pay[0];   // only bit 63 still fits
      default: ;
    endcase

    mag = acc_new[16:1];

    st_nxt           = st;
    st_nxt.prev_id   = prev;
    res_valid        = 1'b0;
    res.header_id    = '0;
    res.header_type  = '0;
    res.is_stop      = 1'b0;
    res.error_code   = cfhd_pkg::ERR_NONE;

    if (!st.in_varint) begin
      if (din.byte_value == 8'd0) begin
        res_valid   = 1'b1;
        res.is_stop = 1'b1;
      end else if (delta != 4'd0) begin
        st_nxt.prev_id  = prev + {12'd0, delta};
        res_valid       = 1'b1;
        res.header_id   = prev + {12'd0, delta};
        res.header_type = din.byte_value[3:0];
      end else begin
        st_nxt.in_varint    = 1'b1;
        st_nxt.pending_type = din.byte_value[3:0];
        st_nxt.acc          = '0;
        st_nxt.ovf          = 1'b0;
        st_nxt.count        = '0;
      end
    end else begin
      st_nxt.acc   = acc_new;
      st_nxt.ovf   = ovf_new;
      st_nxt.count = cnt_inc;
      if (din.byte_value[7]) begin
        if (cnt_inc >= MaxBytes) begin
          res_valid       = 1'b1;
          res.header_type = st.pending_type;
          res.error_code  = cfhd_pkg::ERR_LONG;
        end
      end else begin
        res_valid       = 1'b1;
        res.header_type = st.pending_type;
        if (ovf_new || acc_new[16]) begin
          res.error_code = cfhd_pkg::ERR_RANGE;
        end else begin
          res.header_id  = acc_new[0] ? ~mag : mag;
          st_nxt.prev_id = acc_new[0] ? ~mag : mag;
        end
      end
      if (res_valid) begin
        st_nxt.in_varint = 1'b0;
        st_nxt.acc       = '0;
        st_nxt.ovf       = 1'b0;
        st_nxt.count     = '0;
      end
    end
  end

endmodule

@@ hw/rtl/cfhd_checker.sv @@
module cfhd_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           out_valid,
  input logic           out_ready,
  input cfhd_pkg::out_t out_data
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  a_stop_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.is_stop |->
      out_data.header_id == 16'sd0 && out_data.header_type == 4'd0 &&
      out_data.error_code == cfhd_pkg::ERR_NONE)
    else $error("stop word carries id, type or error");

  a_err_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.error_code != cfhd_pkg::ERR_NONE |->
      out_data.header_id == 16'sd0 && !out_data.is_stop)
    else $error("error word carries an id or stop flag");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

endmodule

bind compact_field_header_decoder cfhd_checker u_cfhd_checker (.*);
